@@ rtl/assert_macros.svh @@
// ---------------------------------------------------------------------------
// assert_macros.svh
// concurrent assertion helpers shared by the rtl
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// next-cycle implication, disabled during reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

@@ rtl/amps_pkg.sv @@
// ---------------------------------------------------------------------------
// amps_pkg
// shared types and codes of the aim micro-pulse sequencer
// ---------------------------------------------------------------------------
`default_nettype none

package amps_pkg;

    typedef logic [1:0]         cmd_t;
    typedef logic [1:0]         act_t;
    typedef logic [31:0]        ms_t;
    typedef logic signed [16:0] err_t;
    typedef logic [15:0]        cfg_word_t;
    typedef logic [2:0]         cfg_idx_t;
    typedef logic [3:0]         frames_t;

    // commands
    localparam cmd_t CMD_TICK   = 2'd0;
    localparam cmd_t CMD_START  = 2'd1;
    localparam cmd_t CMD_CANCEL = 2'd2;

    // servo actions
    localparam act_t ACT_OFF   = 2'd0;
    localparam act_t ACT_STOP  = 2'd1;
    localparam act_t ACT_LEFT  = 2'd2;
    localparam act_t ACT_RIGHT = 2'd3;

    // configuration register indexes
    localparam cfg_idx_t CFG_ALIGNED_TOLERANCE = 3'd0;
    localparam cfg_idx_t CFG_MICRO_RANGE       = 3'd1;
    localparam cfg_idx_t CFG_FINE_RANGE        = 3'd2;
    localparam cfg_idx_t CFG_MEDIUM_RANGE      = 3'd3;
    localparam cfg_idx_t CFG_FRESH_TIMEOUT_MS  = 3'd4;
    localparam cfg_idx_t CFG_PAUSE_MS          = 3'd5;
    localparam cfg_idx_t CFG_REQUIRED_FRAMES   = 3'd6;

    // pulse durations in ms
    localparam logic [15:0] FINE_PULSE_MS   = 16'd40;
    localparam logic [15:0] MEDIUM_PULSE_MS = 16'd80;
    localparam logic [15:0] COARSE_PULSE_MS = 16'd120;

    typedef struct packed {
        cfg_word_t aligned_tolerance;
        cfg_word_t micro_range;
        cfg_word_t fine_range;
        cfg_word_t medium_range;
        cfg_word_t fresh_timeout_ms;
        cfg_word_t pause_ms;
        frames_t   required_frames;
    } cfg_t;

    typedef struct packed {
        logic    manual_on;
        act_t    manual_act;
        ms_t     manual_end_ms;
        act_t    pulse_act;
        ms_t     pulse_end_ms;
        ms_t     next_allowed_ms;
        ms_t     last_seq;
        act_t    pending_act;
        frames_t match_count;
    } state_t;

    typedef struct packed {
        cmd_t command;
        ms_t  now_ms;
        err_t aim_error;
        logic tracking_enabled;
        logic has_message;
        logic tags_visible;
        ms_t  message_time_ms;
        ms_t  frame_sequence;
        act_t manual_direction;
        ms_t  manual_deadline_ms;
    } item_t;

endpackage

`default_nettype wire

@@ rtl/amps_req_if.sv @@
// ---------------------------------------------------------------------------
// amps_req_if
// valid/ready channel carrying one sequencer command transaction
// ---------------------------------------------------------------------------
`default_nettype none

interface amps_req_if import amps_pkg::*;;
    logic valid;
    logic ready;
    cmd_t command;
    ms_t  now_ms;
    err_t aim_error;
    logic tracking_enabled;
    logic has_message;
    logic tags_visible;
    ms_t  message_time_ms;
    ms_t  frame_sequence;
    act_t manual_direction;
    ms_t  manual_deadline_ms;

    modport source (
        output valid, command, now_ms, aim_error, tracking_enabled, has_message,
               tags_visible, message_time_ms, frame_sequence, manual_direction,
               manual_deadline_ms,
        input  ready
    );

    modport sink (
        input  valid, command, now_ms, aim_error, tracking_enabled, has_message,
               tags_visible, message_time_ms, frame_sequence, manual_direction,
               manual_deadline_ms,
        output ready
    );
endinterface

`default_nettype wire

@@ rtl/amps_rsp_if.sv @@
// ---------------------------------------------------------------------------
// amps_rsp_if
// valid/ready channel carrying one aim action transaction
// ---------------------------------------------------------------------------
`default_nettype none

interface amps_rsp_if import amps_pkg::*;;
    logic valid;
    logic ready;
    act_t aim_action;
    logic manual_active;

    modport source (
        output valid, aim_action, manual_active,
        input  ready
    );

    modport sink (
        input  valid, aim_action, manual_active,
        output ready
    );
endinterface

`default_nettype wire

@@ rtl/amps_decide.sv @@
// ---------------------------------------------------------------------------
// amps_decide
// per-transaction decision logic: next state and servo action
// ---------------------------------------------------------------------------
`default_nettype none

module amps_decide import amps_pkg::*;
(
    input  cfg_t   cfg,
    input  state_t state_cur,
    input  item_t  item,
    output state_t state_next,
    output logic   has_result,
    output act_t   aim_action
);

    // signed wrap-around compare: deadline not yet reached
    function automatic logic before_deadline(ms_t now, ms_t deadline);
        ms_t diff;
        diff = now - deadline;
        return diff[31];
    endfunction

    function automatic state_t clear_tracking(state_t s, ms_t seq);
        state_t r;
        r                 = s;
        r.pulse_act       = ACT_STOP;
        r.pulse_end_ms    = '0;
        r.next_allowed_ms = '0;
        r.last_seq        = seq;
        r.pending_act     = ACT_STOP;
        r.match_count     = '0;
        return r;
    endfunction

    logic [16:0] mag;
    act_t        want;
    ms_t         msg_age;
    logic        stale;
    logic [15:0] pulse_len;

    assign mag     = item.aim_error[16] ? 17'(-item.aim_error) : 17'(item.aim_error);
    assign want    = (!item.aim_error[16] && (item.aim_error != '0)) ? ACT_RIGHT : ACT_LEFT;
    assign msg_age = item.now_ms - item.message_time_ms;
    assign stale   = !item.tracking_enabled || !item.has_message || !item.tags_visible
                   || (msg_age > {16'd0, cfg.fresh_timeout_ms});

    always_comb
    begin
        if (mag <= {1'b0, cfg.fine_range})
        begin
            pulse_len = FINE_PULSE_MS;
        end
        else if (mag <= {1'b0, cfg.medium_range})
        begin
            pulse_len = MEDIUM_PULSE_MS;
        end
        else
        begin
            pulse_len = COARSE_PULSE_MS;
        end
    end

    always_comb
    begin
        state_t s;
        logic   done;
        s          = state_cur;
        done       = 1'b0;
        aim_action = ACT_OFF;
        has_result = 1'b0;
        unique case (item.command)
            CMD_START:
            begin
                s.manual_on     = 1'b1;
                s.manual_act    = item.manual_direction;
                s.manual_end_ms = item.manual_deadline_ms;
            end
            CMD_CANCEL:
            begin
                s.manual_on     = 1'b0;
                s.manual_act    = ACT_STOP;
                s.manual_end_ms = '0;
            end
            CMD_TICK:
            begin
                has_result = 1'b1;
                if (s.manual_on)
                begin
                    s = clear_tracking(s, item.frame_sequence);
                    if (before_deadline(item.now_ms, s.manual_end_ms))
                    begin
                        aim_action = s.manual_act;
                        done       = 1'b1;
                    end
                    else
                    begin
                        s.manual_on     = 1'b0;
                        s.manual_act    = ACT_STOP;
                        s.manual_end_ms = '0;
                    end
                end
                if (!done)
                begin
                    if (stale || (mag <= {1'b0, cfg.aligned_tolerance}))
                    begin
                        s          = clear_tracking(s, item.frame_sequence);
                        aim_action = ACT_OFF;
                    end
                    else if (mag > {1'b0, cfg.micro_range})
                    begin
                        s          = clear_tracking(s, item.frame_sequence);
                        aim_action = want;
                    end
                    else if (s.pulse_act != ACT_STOP)
                    begin
                        if (want != s.pulse_act)
                        begin
                            // reversal aborts the running pulse
                            s                 = clear_tracking(s, item.frame_sequence);
                            s.next_allowed_ms = item.now_ms + {16'd0, cfg.pause_ms};
                            aim_action        = ACT_OFF;
                        end
                        else if (before_deadline(item.now_ms, s.pulse_end_ms))
                        begin
                            aim_action = s.pulse_act;
                        end
                        else
                        begin
                            s.pulse_act       = ACT_STOP;
                            s.pulse_end_ms    = '0;
                            s.next_allowed_ms = item.now_ms + {16'd0, cfg.pause_ms};
                            s.pending_act     = ACT_STOP;
                            s.match_count     = '0;
                            aim_action        = ACT_OFF;
                        end
                    end
                    else if (before_deadline(item.now_ms, s.next_allowed_ms))
                    begin
                        aim_action = ACT_OFF;
                    end
                    else
                    begin
                        if (item.frame_sequence != s.last_seq)
                        begin
                            s.last_seq = item.frame_sequence;
                            if (want == s.pending_act)
                            begin
                                if (s.match_count < cfg.required_frames)
                                begin
                                    s.match_count = s.match_count + 4'd1;
                                end
                            end
                            else
                            begin
                                s.pending_act = want;
                                s.match_count = 4'd1;
                            end
                        end
                        if (s.match_count < cfg.required_frames)
                        begin
                            aim_action = ACT_OFF;
                        end
                        else
                        begin
                            s.pulse_act    = want;
                            s.pulse_end_ms = item.now_ms + {16'd0, pulse_len};
                            s.pending_act  = ACT_STOP;
                            s.match_count  = '0;
                            aim_action     = want;
                        end
                    end
                end
            end
            default:
            begin
                // unused command code: no result, no state change
            end
        endcase
        state_next = s;
    end

endmodule

`default_nettype wire

@@ rtl/aim_micro_pulse_sequencer_core.sv @@
// ---------------------------------------------------------------------------
// aim_micro_pulse_sequencer_core
// turret aim servo sequencer with manual override and micro-pulse tracking
// ---------------------------------------------------------------------------
// usage
//   req carries one command transaction: tick, start manual aim or cancel.
//   a tick returns one transaction on rsp with the servo action and the
//   manual override flag; start and cancel only update the manual state.
//   configuration is written through cfg_we / cfg_index / cfg_wdata while
//   the block is idle; a write takes effect on the next edge.
// pipeline and throughput
//   a transaction lands in the input register, the decision logic then runs
//   combinationally from that register into the result and state registers,
//   so a tick passes the input and result registers on its way to rsp. one
//   transaction is accepted every cycle while rsp is not stalled; the state
//   feedback loop runs through the decision logic and the state register.
// reset and stall
//   rst_n clears the state and loads the configuration defaults. while rsp
//   is stalled the result register holds; the input register still takes
//   one more transaction and start or cancel keep flowing past it.
// ---------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module aim_micro_pulse_sequencer_core import amps_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  cfg_we,
    input  cfg_idx_t   cfg_index,
    input  cfg_word_t  cfg_wdata,
    amps_req_if.sink   req,
    amps_rsp_if.source rsp
);

    // configuration registers
    cfg_t   cfg_reg;

    // block state
    state_t state_reg;
    state_t state_next;

    // input register stage
    logic   in_valid_reg;
    item_t  item_reg;

    // result register stage
    logic   out_valid_reg;
    act_t   aim_action_reg;
    logic   manual_active_reg;

    logic   has_result;
    act_t   aim_action_next;
    logic   adv;

    amps_decide u_decide (
        .cfg        (cfg_reg),
        .state_cur  (state_reg),
        .item       (item_reg),
        .state_next (state_next),
        .has_result (has_result),
        .aim_action (aim_action_next)
    );

    // the stored transaction moves on unless it needs a slot that is still full
    assign adv       = in_valid_reg && (!has_result || !out_valid_reg || rsp.ready);
    assign req.ready = !in_valid_reg || adv;

    assign rsp.valid         = out_valid_reg;
    assign rsp.aim_action    = aim_action_reg;
    assign rsp.manual_active = manual_active_reg;

    // configuration write port
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.aligned_tolerance <= 16'd256;
            cfg_reg.micro_range       <= 16'd1280;
            cfg_reg.fine_range        <= 16'd512;
            cfg_reg.medium_range      <= 16'd1024;
            cfg_reg.fresh_timeout_ms  <= 16'd500;
            cfg_reg.pause_ms          <= 16'd200;
            cfg_reg.required_frames   <= 4'd2;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_ALIGNED_TOLERANCE: cfg_reg.aligned_tolerance <= cfg_wdata;
                CFG_MICRO_RANGE:       cfg_reg.micro_range       <= cfg_wdata;
                CFG_FINE_RANGE:        cfg_reg.fine_range        <= cfg_wdata;
                CFG_MEDIUM_RANGE:      cfg_reg.medium_range      <= cfg_wdata;
                CFG_FRESH_TIMEOUT_MS:  cfg_reg.fresh_timeout_ms  <= cfg_wdata;
                CFG_PAUSE_MS:          cfg_reg.pause_ms          <= cfg_wdata;
                CFG_REQUIRED_FRAMES:   cfg_reg.required_frames   <= cfg_wdata[3:0];
                default:
                begin
                    // index outside the register list is dropped
                end
            endcase
        end
    end

    // state update, one transaction per cycle while the stored one advances
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.manual_on       <= 1'b0;
            state_reg.manual_act      <= ACT_STOP;
            state_reg.manual_end_ms   <= '0;
            state_reg.pulse_act       <= ACT_STOP;
            state_reg.pulse_end_ms    <= '0;
            state_reg.next_allowed_ms <= '0;
            state_reg.last_seq        <= '0;
            state_reg.pending_act     <= ACT_STOP;
            state_reg.match_count     <= '0;
        end
        else if (adv)
        begin
            state_reg <= state_next;
        end
    end

    // input register control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (req.ready)
        begin
            in_valid_reg <= req.valid;
        end
    end

    // input register payload
    always_ff @(posedge clk)
    begin
        if (req.valid && req.ready)
        begin
            item_reg.command            <= req.command;
            item_reg.now_ms             <= req.now_ms;
            item_reg.aim_error          <= req.aim_error;
            item_reg.tracking_enabled   <= req.tracking_enabled;
            item_reg.has_message        <= req.has_message;
            item_reg.tags_visible       <= req.tags_visible;
            item_reg.message_time_ms    <= req.message_time_ms;
            item_reg.frame_sequence     <= req.frame_sequence;
            item_reg.manual_direction   <= req.manual_direction;
            item_reg.manual_deadline_ms <= req.manual_deadline_ms;
        end
    end

    // result register control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv && has_result)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // result register payload
    always_ff @(posedge clk)
    begin
        if (adv && has_result)
        begin
            aim_action_reg    <= aim_action_next;
            manual_active_reg <= state_next.manual_on;
        end
    end

    // a reported manual flag matches the stored override state
    `ASSERT_NEXT(a_rsp_manual_flag, clk, rst_n, adv && has_result,
                 out_valid_reg && (manual_active_reg == state_reg.manual_on))
    // a held transaction in the input register is not overwritten
    `ASSERT_NEXT(a_in_hold, clk, rst_n, in_valid_reg && !adv,
                 in_valid_reg && $stable(item_reg))
    // a pulse is only ever left, right or none
    `ASSERT_IMPLIES(a_pulse_act_code, clk, rst_n, 1'b1, state_reg.pulse_act != ACT_OFF)
    // a pending result is never dropped while the receiver stalls
    `ASSERT_NEXT(a_rsp_hold, clk, rst_n, out_valid_reg && !rsp.ready,
                 out_valid_reg && $stable(aim_action_reg))

endmodule

`default_nettype wire

@@ verif/aim_micro_pulse_sequencer_core_tb.sv @@
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// aim_micro_pulse_sequencer_core_tb
// self-checking bench: directed and random command transactions with a
// cycle-free aim predictor and in-order comparison of every tick result
// ---------------------------------------------------------------------------

module aim_micro_pulse_sequencer_core_tb;

    import amps_pkg::*;

    // command code the block must ignore
    localparam cmd_t CMD_UNUSED = 2'd3;

    // result of one tick as seen on rsp
    typedef struct packed {
        act_t act;
        logic manual;
    } aim_res_t;

    logic      clk;
    logic      rst_n;
    logic      cfg_we;
    cfg_idx_t  cfg_index;
    cfg_word_t cfg_wdata;

    amps_req_if req_bus ();
    amps_rsp_if rsp_bus ();

    aim_micro_pulse_sequencer_core u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .req       (req_bus),
        .rsp       (rsp_bus)
    );

    // pending command transactions, filled by the stimulus process
    item_t    cmd_q[$];
    // aim results predicted but not yet seen on rsp
    aim_res_t aim_expect_q[$];

    // mirror of the configuration and of the sequencer state
    cfg_t   thr;
    state_t trk;

    int driven_cnt;
    int accepted_cnt;
    int tick_cnt;
    int checked_cnt;
    int error_cnt;
    int setting_cnt;

    // scene for the random part: running clock, frame counter, error sign
    ms_t scene_ms;
    ms_t scene_seq;
    bit  scene_right;

    // ------------------------------------------------------------------
    // clock
    // ------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever
        begin
            #5 clk = ~clk;
        end
    end

    // ------------------------------------------------------------------
    // hard limit on the run
    // ------------------------------------------------------------------
    initial
    begin
        #5_000_000;
        $display("timeout with %0d results still outstanding", aim_expect_q.size());
        $display("end of test: mismatches");
        $finish;
    end

    // ------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------

    // deadline not yet reached: signed wrap-around difference is negative
    function automatic bit not_reached(ms_t now, ms_t deadline);
        ms_t diff;
        diff = now - deadline;
        return diff[31];
    endfunction

    // drop any pulse or frame agreement in progress
    task automatic clear_tracking(input ms_t seq);
        trk.pulse_act       = ACT_STOP;
        trk.pulse_end_ms    = '0;
        trk.next_allowed_ms = '0;
        trk.last_seq        = seq;
        trk.pending_act     = ACT_STOP;
        trk.match_count     = '0;
    endtask

    // servo decision for one tick, updates trk
    task automatic aim_decide(input item_t it, output act_t act);
        int   err;
        int   mag;
        ms_t  age;
        ms_t  plen;
        act_t want;
        act = ACT_OFF;
        err = int'(it.aim_error);
        // manual override wins until its deadline
        if (trk.manual_on)
        begin
            clear_tracking(it.frame_sequence);
            if (not_reached(it.now_ms, trk.manual_end_ms))
            begin
                act = trk.manual_act;
                return;
            end
            trk.manual_on     = 1'b0;
            trk.manual_act    = ACT_STOP;
            trk.manual_end_ms = '0;
        end
        // no usable tracking data
        age = it.now_ms - it.message_time_ms;
        if (!it.tracking_enabled || !it.has_message || !it.tags_visible ||
            age > {16'd0, thr.fresh_timeout_ms})
        begin
            clear_tracking(it.frame_sequence);
            return;
        end
        mag = (err < 0) ? -err : err;
        if (mag <= thr.aligned_tolerance)
        begin
            clear_tracking(it.frame_sequence);
            return;
        end
        want = (err > 0) ? ACT_RIGHT : ACT_LEFT;
        // far off target: continuous drive
        if (mag > thr.micro_range)
        begin
            clear_tracking(it.frame_sequence);
            act = want;
            return;
        end
        // a pulse is running
        if (trk.pulse_act != ACT_STOP)
        begin
            if (want != trk.pulse_act)
            begin
                // reversal aborts the pulse and starts a pause
                clear_tracking(it.frame_sequence);
                trk.next_allowed_ms = it.now_ms + {16'd0, thr.pause_ms};
                return;
            end
            if (not_reached(it.now_ms, trk.pulse_end_ms))
            begin
                act = trk.pulse_act;
                return;
            end
            trk.pulse_act       = ACT_STOP;
            trk.pulse_end_ms    = '0;
            trk.next_allowed_ms = it.now_ms + {16'd0, thr.pause_ms};
            trk.pending_act     = ACT_STOP;
            trk.match_count     = '0;
            return;
        end
        if (not_reached(it.now_ms, trk.next_allowed_ms))
            return;
        // count new frames that agree on direction, saturating
        if (it.frame_sequence != trk.last_seq)
        begin
            trk.last_seq = it.frame_sequence;
            if (want == trk.pending_act)
            begin
                if (trk.match_count < thr.required_frames)
                    trk.match_count = trk.match_count + 1'b1;
            end
            else
            begin
                trk.pending_act = want;
                trk.match_count = 4'd1;
            end
        end
        if (trk.match_count < thr.required_frames)
            return;
        // fire a micro-pulse sized by the error
        if (mag <= thr.fine_range)
            plen = {16'd0, FINE_PULSE_MS};
        else if (mag <= thr.medium_range)
            plen = {16'd0, MEDIUM_PULSE_MS};
        else
            plen = {16'd0, COARSE_PULSE_MS};
        trk.pulse_act    = want;
        trk.pulse_end_ms = it.now_ms + plen;
        trk.pending_act  = ACT_STOP;
        trk.match_count  = '0;
        act = want;
    endtask

    // ------------------------------------------------------------------
    // transaction capture and result check, both on the rising edge;
    // acceptance is handled first so a fast result still finds its
    // expectation
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        item_t    it;
        aim_res_t want;
        aim_res_t got;
        act_t     act;
        if (rst_n)
        begin
            if (req_bus.valid && req_bus.ready)
            begin
                it.command            = req_bus.command;
                it.now_ms             = req_bus.now_ms;
                it.aim_error          = req_bus.aim_error;
                it.tracking_enabled   = req_bus.tracking_enabled;
                it.has_message        = req_bus.has_message;
                it.tags_visible       = req_bus.tags_visible;
                it.message_time_ms    = req_bus.message_time_ms;
                it.frame_sequence     = req_bus.frame_sequence;
                it.manual_direction   = req_bus.manual_direction;
                it.manual_deadline_ms = req_bus.manual_deadline_ms;
                accepted_cnt++;
                case (it.command)
                    CMD_TICK:
                    begin
                        aim_decide(it, act);
                        aim_expect_q.push_back('{act: act, manual: trk.manual_on});
                        tick_cnt++;
                    end
                    CMD_START:
                    begin
                        trk.manual_on     = 1'b1;
                        trk.manual_act    = it.manual_direction;
                        trk.manual_end_ms = it.manual_deadline_ms;
                    end
                    CMD_CANCEL:
                    begin
                        trk.manual_on     = 1'b0;
                        trk.manual_act    = ACT_STOP;
                        trk.manual_end_ms = '0;
                    end
                    default: ;  // unused code: no effect
                endcase
            end
            if (rsp_bus.valid && rsp_bus.ready)
            begin
                got = '{act: rsp_bus.aim_action, manual: rsp_bus.manual_active};
                if (aim_expect_q.size() == 0)
                begin
                    error_cnt++;
                    $display("%0t: unexpected result, action %0d manual %0b",
                             $time, got.act, got.manual);
                end
                else
                begin
                    want = aim_expect_q.pop_front();
                    checked_cnt++;
                    if (got.act !== want.act)
                    begin
                        error_cnt++;
                        $display("%0t: aim_action mismatch, expected %0d, got %0d",
                                 $time, want.act, got.act);
                    end
                    if (got.manual !== want.manual)
                    begin
                        error_cnt++;
                        $display("%0t: manual_active mismatch, expected %0b, got %0b",
                                 $time, want.manual, got.manual);
                    end
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // driver: sender in bursts with gaps, receiver on its own stall pattern
    // ------------------------------------------------------------------
    int burst_left = 1;
    int gap_left   = 0;
    int rcv_cyc    = 0;
    int rcv_mode   = 0;

    always @(negedge clk)
    begin
        item_t nxt;
        bit    rdy;
        if (rst_n)
        begin
            // receiver: pattern drawn from five stall patterns
            if (rcv_cyc % 64 == 0)
                rcv_mode = $urandom_range(0, 4);
            case (rcv_mode)
                0:       rdy = 1'b1;
                1:       rdy = (rcv_cyc % 3) != 0;
                2:       rdy = 1'($urandom_range(0, 1));
                3:       rdy = $urandom_range(0, 4) == 0;
                default: rdy = (rcv_cyc % 16) >= 5;  // long stall then open
            endcase
            rcv_cyc++;
            rsp_bus.ready <= rdy;

            // sender: present the next transaction once the current one is taken
            if (!req_bus.valid || accepted_cnt == driven_cnt)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    req_bus.valid <= 1'b0;
                end
                else if (cmd_q.size() > 0)
                begin
                    nxt = cmd_q.pop_front();
                    req_bus.command            <= nxt.command;
                    req_bus.now_ms             <= nxt.now_ms;
                    req_bus.aim_error          <= nxt.aim_error;
                    req_bus.tracking_enabled   <= nxt.tracking_enabled;
                    req_bus.has_message        <= nxt.has_message;
                    req_bus.tags_visible       <= nxt.tags_visible;
                    req_bus.message_time_ms    <= nxt.message_time_ms;
                    req_bus.frame_sequence     <= nxt.frame_sequence;
                    req_bus.manual_direction   <= nxt.manual_direction;
                    req_bus.manual_deadline_ms <= nxt.manual_deadline_ms;
                    req_bus.valid              <= 1'b1;
                    driven_cnt++;
                    burst_left--;
                    if (burst_left <= 0)
                    begin
                        // some bursts run long with no gap at all
                        if ($urandom_range(0, 3) == 0)
                        begin
                            burst_left = $urandom_range(20, 60);
                            gap_left   = 0;
                        end
                        else
                        begin
                            burst_left = $urandom_range(1, 12);
                            gap_left   = $urandom_range(1, 6);
                        end
                    end
                end
                else
                begin
                    req_bus.valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------

    // fully random transaction, command set to tick
    function automatic item_t rand_item();
        item_t it;
        int    e;
        e = $urandom_range(0, 92160);
        e = e - 46080;
        it.command            = CMD_TICK;
        it.now_ms             = $urandom;
        it.aim_error          = e[16:0];
        it.tracking_enabled   = 1'($urandom_range(0, 1));
        it.has_message        = 1'($urandom_range(0, 1));
        it.tags_visible       = 1'($urandom_range(0, 1));
        it.message_time_ms    = $urandom;
        it.frame_sequence     = $urandom;
        it.manual_direction   = act_t'($urandom_range(0, 3));
        it.manual_deadline_ms = $urandom;
        return it;
    endfunction

    // queue a tick with the message age given relative to now
    task automatic push_tick(input ms_t now, input int err, input bit en, input bit hm,
                             input bit vis, input ms_t age, input ms_t seq);
        item_t it;
        it = rand_item();
        it.now_ms           = now;
        it.aim_error        = err[16:0];
        it.tracking_enabled = en;
        it.has_message      = hm;
        it.tags_visible     = vis;
        it.message_time_ms  = now - age;
        it.frame_sequence   = seq;
        cmd_q.push_back(it);
    endtask

    task automatic push_manual(input cmd_t cmd, input act_t dir, input ms_t deadline);
        item_t it;
        it = rand_item();
        it.command            = cmd;
        it.manual_direction   = dir;
        it.manual_deadline_ms = deadline;
        cmd_q.push_back(it);
    endtask

    // one register write on the falling edge, mirror follows
    task automatic write_reg(input cfg_idx_t idx, input cfg_word_t val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        case (idx)
            CFG_ALIGNED_TOLERANCE: thr.aligned_tolerance = val;
            CFG_MICRO_RANGE:       thr.micro_range       = val;
            CFG_FINE_RANGE:        thr.fine_range        = val;
            CFG_MEDIUM_RANGE:      thr.medium_range      = val;
            CFG_FRESH_TIMEOUT_MS:  thr.fresh_timeout_ms  = val;
            CFG_PAUSE_MS:          thr.pause_ms          = val;
            CFG_REQUIRED_FRAMES:   thr.required_frames   = val[3:0];
            default: ;
        endcase
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic load_setting(input cfg_t c);
        write_reg(CFG_ALIGNED_TOLERANCE, c.aligned_tolerance);
        write_reg(CFG_MICRO_RANGE,       c.micro_range);
        write_reg(CFG_FINE_RANGE,        c.fine_range);
        write_reg(CFG_MEDIUM_RANGE,      c.medium_range);
        write_reg(CFG_FRESH_TIMEOUT_MS,  c.fresh_timeout_ms);
        write_reg(CFG_PAUSE_MS,          c.pause_ms);
        write_reg(CFG_REQUIRED_FRAMES,   {12'd0, c.required_frames});
        setting_cnt++;
    endtask

    // wait until everything queued has gone through and every result is in;
    // start and cancel leave no result, so a closing wait covers them
    task automatic wait_drained();
        int guard;
        guard = 0;
        while ((cmd_q.size() != 0 || accepted_cnt != driven_cnt ||
                aim_expect_q.size() != 0) && guard < 20000)
        begin
            @(posedge clk);
            guard++;
        end
        if (aim_expect_q.size() != 0)
        begin
            error_cnt++;
            $display("%0t: %0d expected results never arrived", $time, aim_expect_q.size());
            aim_expect_q.delete();
        end
        repeat (6) @(posedge clk);
    endtask

    // random part: mostly coherent tracking scenes, some manual traffic and noise
    task automatic push_scene(input int n);
        item_t it;
        int    r;
        int    lo;
        int    hi;
        int    mag;
        ms_t   age;
        // start the scene clock somewhere, sometimes just below the wrap
        if ($urandom_range(0, 2) == 0)
            scene_ms = 32'hFFFF_FFFF - $urandom_range(0, 3000);
        else
            scene_ms = $urandom;
        scene_seq = $urandom;
        for (int k = 0; k < n; k++)
        begin
            r = $urandom_range(0, 99);
            if (r < 4)
            begin
                push_manual(CMD_START, act_t'($urandom_range(0, 3)),
                            ($urandom_range(0, 9) == 0) ? ms_t'($urandom)
                                                        : scene_ms + $urandom_range(0, 300));
            end
            else if (r < 6)
            begin
                push_manual(CMD_CANCEL, act_t'($urandom_range(0, 3)), $urandom);
            end
            else if (r < 7)
            begin
                push_manual(CMD_UNUSED, act_t'($urandom_range(0, 3)), $urandom);
            end
            else if (r < 17)
            begin
                // noise tick
                it = rand_item();
                if ($urandom_range(0, 1))
                    it.now_ms = scene_ms;
                cmd_q.push_back(it);
            end
            else
            begin
                scene_ms = scene_ms + (($urandom_range(0, 9) == 0) ? $urandom_range(0, 400)
                                                                   : $urandom_range(0, 40));
                if ($urandom_range(0, 9) < 7)
                    scene_seq = scene_seq + 1;
                if ($urandom_range(0, 99) < 8)
                    scene_right = ~scene_right;
                // magnitude mostly inside the micro-pulse band
                lo = thr.aligned_tolerance + 1;
                hi = (thr.micro_range > 46080) ? 46080 : thr.micro_range;
                if ($urandom_range(0, 3) != 0 && lo <= hi)
                    mag = $urandom_range(lo, hi);
                else
                    mag = $urandom_range(0, 46080);
                if ($urandom_range(0, 9) == 0)
                    age = thr.fresh_timeout_ms + $urandom_range(1, 100);
                else
                    age = $urandom_range(0, thr.fresh_timeout_ms);
                push_tick(scene_ms, scene_right ? mag : -mag,
                          $urandom_range(0, 19) != 0, $urandom_range(0, 19) != 0,
                          $urandom_range(0, 19) != 0, age, scene_seq);
            end
        end
    endtask

    // ------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------
    initial
    begin
        cfg_t c;
        ms_t  t;
        // known values on every input from time zero
        rst_n     = 1'b0;
        cfg_we    = 1'b0;
        cfg_index = CFG_ALIGNED_TOLERANCE;
        cfg_wdata = '0;
        req_bus.valid              = 1'b0;
        req_bus.command            = CMD_TICK;
        req_bus.now_ms             = '0;
        req_bus.aim_error          = '0;
        req_bus.tracking_enabled   = 1'b0;
        req_bus.has_message        = 1'b0;
        req_bus.tags_visible       = 1'b0;
        req_bus.message_time_ms    = '0;
        req_bus.frame_sequence     = '0;
        req_bus.manual_direction   = ACT_STOP;
        req_bus.manual_deadline_ms = '0;
        rsp_bus.ready              = 1'b0;

        // reset values of the configuration and the state
        thr = '{aligned_tolerance: 16'd256, micro_range: 16'd1280, fine_range: 16'd512,
                medium_range: 16'd1024, fresh_timeout_ms: 16'd500, pause_ms: 16'd200,
                required_frames: 4'd2};
        trk = '{manual_on: 1'b0, manual_act: ACT_STOP, manual_end_ms: '0,
                pulse_act: ACT_STOP, pulse_end_ms: '0, next_allowed_ms: '0,
                last_seq: '0, pending_act: ACT_STOP, match_count: '0};
        scene_right = 1'b1;
        setting_cnt = 1;

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(posedge clk);

        // directed part at the reset configuration
        t = 32'd1000;
        push_tick(t,      600,    1'b0, 1'b1, 1'b1, 0,   1);   // tracking disabled
        push_tick(t + 1,  600,    1'b1, 1'b0, 1'b1, 0,   1);   // no message yet
        push_tick(t + 2,  600,    1'b1, 1'b1, 1'b0, 0,   1);   // tags lost
        push_tick(t + 3,  600,    1'b1, 1'b1, 1'b1, 501, 1);   // stale by one ms
        push_tick(t + 4,  256,    1'b1, 1'b1, 1'b1, 500, 2);   // aligned at tolerance
        push_tick(t + 5,  46080,  1'b1, 1'b1, 1'b1, 0,   3);   // far right
        push_tick(t + 6,  -46080, 1'b1, 1'b1, 1'b1, 0,   4);   // far left
        push_tick(t + 10, -600,   1'b1, 1'b1, 1'b1, 0,   10);  // first agreeing frame
        push_tick(t + 20, -600,   1'b1, 1'b1, 1'b1, 0,   11);  // second: left pulse
        push_tick(t + 30, -600,   1'b1, 1'b1, 1'b1, 0,   11);  // pulse still running
        push_tick(t + 40, 600,    1'b1, 1'b1, 1'b1, 0,   12);  // reversal aborts
        push_tick(t + 100, 300,   1'b1, 1'b1, 1'b1, 0,   13);  // inside the pause
        push_tick(t + 300, 300,   1'b1, 1'b1, 1'b1, 0,   14);
        push_tick(t + 310, 300,   1'b1, 1'b1, 1'b1, 0,   15);  // fine right pulse
        push_tick(t + 400, 300,   1'b1, 1'b1, 1'b1, 0,   15);  // pulse over
        push_manual(CMD_START, ACT_LEFT, t + 500);
        push_tick(t + 450, 0,     1'b1, 1'b1, 1'b1, 0,   16);  // override holds
        push_tick(t + 500, 1000,  1'b1, 1'b1, 1'b1, 0,   17);  // deadline reached
        push_manual(CMD_START, ACT_OFF, t + 10000);             // zero direction
        push_tick(t + 600, 1000,  1'b1, 1'b1, 1'b1, 0,   18);
        push_manual(CMD_CANCEL, ACT_RIGHT, 32'hFFFF_FFFF);
        push_manual(CMD_UNUSED, ACT_RIGHT, 32'h0000_0000);
        // coarse-band ticks across the clock wrap; no pulse fires
        push_tick(32'hFFFF_FFF0, 1200, 1'b1, 1'b1, 1'b1, 0,   32'hFFFF_FFFE);
        push_tick(32'hFFFF_FFF8, 1200, 1'b1, 1'b1, 1'b1, 8,   32'hFFFF_FFFF);
        push_tick(32'h0000_0010, 1200, 1'b1, 1'b1, 1'b1, 288, 32'hFFFF_FFFF);
        wait_drained();

        // random part at the reset configuration
        push_scene(300);
        wait_drained();

        // widest bands, longest freshness, no pause, single frame
        c = '{aligned_tolerance: 16'd0, micro_range: 16'd46080, fine_range: 16'd0,
              medium_range: 16'd46080, fresh_timeout_ms: 16'hFFFF, pause_ms: 16'd0,
              required_frames: 4'd1};
        load_setting(c);
        push_scene(200);
        wait_drained();

        // everything counts as aligned, zero freshness, longest pause, most frames
        c = '{aligned_tolerance: 16'd46080, micro_range: 16'd0, fine_range: 16'd46080,
              medium_range: 16'd0, fresh_timeout_ms: 16'd0, pause_ms: 16'hFFFF,
              required_frames: 4'd15};
        load_setting(c);
        push_scene(60);
        wait_drained();

        // no agreement needed: a pulse fires as soon as the pause is over
        c = '{aligned_tolerance: 16'd100, micro_range: 16'd3000, fine_range: 16'd1000,
              medium_range: 16'd2000, fresh_timeout_ms: 16'd300, pause_ms: 16'd0,
              required_frames: 4'd0};
        load_setting(c);
        push_scene(200);
        wait_drained();

        // fifteen agreeing frames, so the match count saturates
        c = '{aligned_tolerance: 16'd256, micro_range: 16'd2000, fine_range: 16'd600,
              medium_range: 16'd1400, fresh_timeout_ms: 16'd1000, pause_ms: 16'd50,
              required_frames: 4'd15};
        load_setting(c);
        push_scene(250);
        wait_drained();

        // random settings with ordered bands
        repeat (2)
        begin
            c.aligned_tolerance = cfg_word_t'($urandom_range(0, 800));
            c.micro_range       = cfg_word_t'(c.aligned_tolerance + $urandom_range(0, 4000));
            c.fine_range        = cfg_word_t'($urandom_range(0, c.micro_range));
            c.medium_range      = cfg_word_t'($urandom_range(c.fine_range, c.micro_range));
            c.fresh_timeout_ms  = cfg_word_t'($urandom_range(0, 2000));
            c.pause_ms          = cfg_word_t'($urandom_range(0, 400));
            c.required_frames   = frames_t'($urandom_range(1, 6));
            load_setting(c);
            push_scene(170);
            wait_drained();
        end

        repeat (10) @(posedge clk);
        $display("%0d command transactions over %0d configuration settings", accepted_cnt,
                 setting_cnt);
        $display("%0d of %0d tick results compared, %0d errors", checked_cnt, tick_cnt,
                 error_cnt);
        if (error_cnt == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
